// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle rule");

// Next-cycle implication, sampled on the rising edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle rule");

`endif

// File: hdl/i2a_pkg.sv
package i2a_pkg;

    // Mode codes
    localparam logic [2:0] MODE_SDEC  = 3'd0;
    localparam logic [2:0] MODE_UDEC  = 3'd1;
    localparam logic [2:0] MODE_PTR   = 3'd2;
    localparam logic [2:0] MODE_LHEX  = 3'd3;
    localparam logic [2:0] MODE_UHEX  = 3'd4;

    // Sizes
    localparam int DIG_W        = 64;   // digit register, 16 nibbles, top aligned
    localparam int NDIG_W       = 5;    // holds 1..16
    localparam int DEC_DIGITS   = 10;
    localparam int HEX32_DIGITS = 8;
    localparam int HEX64_DIGITS = 16;
    localparam int DABBLE_STEPS = 32;
    localparam int STEP_W       = 5;

    // ASCII codes
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_X     = 7'h78;
    localparam logic [6:0] CH_LA    = 7'h61;
    localparam logic [6:0] CH_UA    = 7'h41;

    typedef enum logic [1:0] {
        PFX_NONE  = 2'd0,
        PFX_MINUS = 2'd1,
        PFX_HEX   = 2'd2
    } prefix_t;

    // Converted number handed from converter to emitter
    typedef struct packed {
        logic [DIG_W-1:0]  digits;
        logic [NDIG_W-1:0] ndig;
        prefix_t           prefix;
        logic              upper;
    } job_t;

    // Nibble to ASCII digit
    function automatic logic [6:0] nib2char(input logic [3:0] nib, input logic upper);
        logic [6:0] base;
        begin
            base = upper ? CH_UA : CH_LA;
            if (nib < 4'd10)
                nib2char = CH_ZERO + {3'd0, nib};
            else
                nib2char = base + {3'd0, nib - 4'd10};
        end
    endfunction

endpackage

// File: hdl/i2a_conv.sv
module i2a_conv (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [2:0]     mode,
    input  logic [63:0]    value,
    output logic           job_valid,
    input  logic           job_take,
    output i2a_pkg::job_t  job
);

    typedef enum logic [3:0] {
        C_IDLE   = 4'b0001,
        C_DABBLE = 4'b0010,
        C_STRIP  = 4'b0100,
        C_DONE   = 4'b1000
    } conv_state_t;

    conv_state_t                    state_reg, state_next;
    logic [i2a_pkg::DIG_W-1:0]      digits_reg, digits_next;
    logic [i2a_pkg::NDIG_W-1:0]     ndig_reg, ndig_next;
    logic [31:0]                    sh_reg, sh_next;
    logic [i2a_pkg::STEP_W-1:0]     step_reg, step_next;
    i2a_pkg::prefix_t               prefix_reg, prefix_next;
    logic                           upper_reg, upper_next;

    logic [4*i2a_pkg::DEC_DIGITS-1:0] bcd_adj;
    logic [31:0]                      low;
    logic                             accept;

    assign low      = value[31:0];
    assign in_stall = (state_reg != C_IDLE);
    assign accept   = in_valid && !in_stall;

    // Add-3 on every BCD digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < i2a_pkg::DEC_DIGITS; i++)
        begin
            if (digits_reg[i2a_pkg::DIG_W-4*i2a_pkg::DEC_DIGITS+4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] =
                    digits_reg[i2a_pkg::DIG_W-4*i2a_pkg::DEC_DIGITS+4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] =
                    digits_reg[i2a_pkg::DIG_W-4*i2a_pkg::DEC_DIGITS+4*i +: 4];
        end
    end

    // Sequencer: load, shift-add-3 (decimal only), strip leading zeros, hand off
    always_comb
    begin
        state_next  = state_reg;
        digits_next = digits_reg;
        ndig_next   = ndig_reg;
        sh_next     = sh_reg;
        step_next   = step_reg;
        prefix_next = prefix_reg;
        upper_next  = upper_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (accept)
                begin
                    step_next   = '0;
                    upper_next  = 1'b0;
                    prefix_next = i2a_pkg::PFX_NONE;
                    unique case (mode) inside
                        i2a_pkg::MODE_SDEC:
                        begin
                            digits_next = '0;
                            if (low[31])
                            begin
                                prefix_next = i2a_pkg::PFX_MINUS;
                                sh_next     = ~low + 32'd1;
                            end
                            else
                                sh_next = low;
                            state_next = C_DABBLE;
                        end
                        i2a_pkg::MODE_UDEC:
                        begin
                            digits_next = '0;
                            sh_next     = low;
                            state_next  = C_DABBLE;
                        end
                        i2a_pkg::MODE_PTR:
                        begin
                            digits_next = value;
                            ndig_next   = i2a_pkg::NDIG_W'(i2a_pkg::HEX64_DIGITS);
                            prefix_next = i2a_pkg::PFX_HEX;
                            state_next  = C_STRIP;
                        end
                        i2a_pkg::MODE_LHEX, i2a_pkg::MODE_UHEX:
                        begin
                            digits_next = {low, 32'd0};
                            ndig_next   = i2a_pkg::NDIG_W'(i2a_pkg::HEX32_DIGITS);
                            upper_next  = (mode == i2a_pkg::MODE_UHEX);
                            state_next  = C_STRIP;
                        end
                        default:
                            state_next = C_IDLE;   // undefined mode: dropped
                    endcase
                end
            end
            C_DABBLE:
            begin
                digits_next[i2a_pkg::DIG_W-1 -: 4*i2a_pkg::DEC_DIGITS] =
                    {bcd_adj[4*i2a_pkg::DEC_DIGITS-2:0], sh_reg[31]};
                sh_next   = {sh_reg[30:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == i2a_pkg::STEP_W'(i2a_pkg::DABBLE_STEPS - 1))
                begin
                    ndig_next  = i2a_pkg::NDIG_W'(i2a_pkg::DEC_DIGITS);
                    state_next = C_STRIP;
                end
            end
            C_STRIP:
            begin
                if (ndig_reg > i2a_pkg::NDIG_W'(1)
                    && digits_reg[i2a_pkg::DIG_W-1 -: 4] == 4'd0)
                begin
                    digits_next = {digits_reg[i2a_pkg::DIG_W-5:0], 4'd0};
                    ndig_next   = ndig_reg - 1'b1;
                end
                else
                    state_next = C_DONE;
            end
            C_DONE:
            begin
                if (job_take)
                    state_next = C_IDLE;
            end
            default:
                state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= C_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        ndig_reg   <= ndig_next;
        sh_reg     <= sh_next;
        step_reg   <= step_next;
        prefix_reg <= prefix_next;
        upper_reg  <= upper_next;
    end

    assign job_valid  = (state_reg == C_DONE);
    assign job.digits = digits_reg;
    assign job.ndig   = ndig_reg;
    assign job.prefix = prefix_reg;
    assign job.upper  = upper_reg;

endmodule

// File: hdl/i2a_emit.sv
module i2a_emit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_take,
    input  i2a_pkg::job_t  job,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [6:0]     character,
    output logic           last
);

    typedef enum logic [3:0] {
        E_IDLE = 4'b0001,
        E_PFX  = 4'b0010,
        E_X    = 4'b0100,
        E_DIG  = 4'b1000
    } emit_state_t;

    emit_state_t                state_reg, state_next;
    logic [i2a_pkg::DIG_W-1:0]  dig_reg, dig_next;
    logic [i2a_pkg::NDIG_W-1:0] ndig_reg, ndig_next;
    i2a_pkg::prefix_t           prefix_reg, prefix_next;
    logic                       upper_reg, upper_next;
    logic                       ovalid_reg, ovalid_next;
    logic [6:0]                 char_reg, char_next;
    logic                       last_reg, last_next;
    logic                       advance;

    // Output register may load when empty or being taken
    assign advance  = !ovalid_reg || !out_stall;
    assign job_take = (state_reg == E_IDLE) && job_valid;

    always_comb
    begin
        state_next  = state_reg;
        dig_next    = dig_reg;
        ndig_next   = ndig_reg;
        prefix_next = prefix_reg;
        upper_next  = upper_reg;
        ovalid_next = ovalid_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        if (advance)
            ovalid_next = 1'b0;
        unique case (state_reg)
            E_IDLE:
            begin
                if (job_valid)
                begin
                    dig_next    = job.digits;
                    ndig_next   = job.ndig;
                    prefix_next = job.prefix;
                    upper_next  = job.upper;
                    state_next  = (job.prefix == i2a_pkg::PFX_NONE) ? E_DIG : E_PFX;
                end
            end
            E_PFX:
            begin
                if (advance)
                begin
                    ovalid_next = 1'b1;
                    last_next   = 1'b0;
                    if (prefix_reg == i2a_pkg::PFX_MINUS)
                    begin
                        char_next  = i2a_pkg::CH_MINUS;
                        state_next = E_DIG;
                    end
                    else
                    begin
                        char_next  = i2a_pkg::CH_ZERO;
                        state_next = E_X;
                    end
                end
            end
            E_X:
            begin
                if (advance)
                begin
                    ovalid_next = 1'b1;
                    last_next   = 1'b0;
                    char_next   = i2a_pkg::CH_X;
                    state_next  = E_DIG;
                end
            end
            E_DIG:
            begin
                if (advance)
                begin
                    ovalid_next = 1'b1;
                    char_next   = i2a_pkg::nib2char(dig_reg[i2a_pkg::DIG_W-1 -: 4], upper_reg);
                    last_next   = (ndig_reg == i2a_pkg::NDIG_W'(1));
                    dig_next    = {dig_reg[i2a_pkg::DIG_W-5:0], 4'd0};
                    ndig_next   = ndig_reg - 1'b1;
                    if (ndig_reg == i2a_pkg::NDIG_W'(1))
                        state_next = E_IDLE;
                end
            end
            default:
                state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= E_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg    <= dig_next;
        ndig_reg   <= ndig_next;
        prefix_reg <= prefix_next;
        upper_reg  <= upper_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    assign out_valid = ovalid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

// File: hdl/integer_to_ascii_formatter.sv
// Channel   Direction  Handshake             Fields
// input     in         in_valid / in_stall   mode[2:0], value[63:0]
// output    out        out_valid / out_stall character[6:0], last
//
// Decimal: accepted, run through the shift-add-3 loop, stripped of leading zeros, handed
// off. Hex: accepted, stripped of leading zeros from 8 (32-bit) or 16 (pointer) digits,
// handed off. Characters leave one per cycle while out_stall is low, overlapped with the
// next conversion; decimal requests are paced by the double-dabble loop, hex requests by
// the emitter. Reset clears both sequencers and the output valid. out_stall holds the
// output register; in_stall is high while the converter is busy.
`include "assert_macros.svh"

module integer_to_ascii_formatter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [63:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  character,
    output logic        last
);

    i2a_pkg::job_t job;
    logic          job_valid;
    logic          job_take;

    // Serial converter
    i2a_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .value     (value),
        .job_valid (job_valid),
        .job_take  (job_take),
        .job       (job)
    );

    // Character emitter with output register
    i2a_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_take  (job_take),
        .job       (job),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

    // A finished number waiting for the emitter blocks new requests
    `ASSERT_NOW(a_wait_stalls, clk, rst_n, job_valid, in_stall)
    // Converter frees itself right after handoff
    `ASSERT_NEXT(a_take_frees, clk, rst_n, job_take, !job_valid)
    // A handed-off number has at least one digit
    `ASSERT_NOW(a_ndig_nonzero, clk, rst_n, job_valid, job.ndig != 5'd0)
    // Emitted characters are never NUL
    `ASSERT_NOW(a_char_nonnul, clk, rst_n, out_valid, character != 7'd0)

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    // Mode codes the block does not define; requests with them are dropped
    localparam logic [2:0] MODE_RSVD_LO = 3'd5;
    localparam logic [2:0] MODE_RSVD_HI = 3'd7;

    localparam int          RANDOM_QUIET = 40;
    localparam int          RANDOM_BUSY  = 100;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 120;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } text_char_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [2:0]  mode      = i2a_pkg::MODE_SDEC;
    logic [63:0] value     = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [6:0]  character;
    logic        last;

    text_char_t  expected_chars[$];
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;
    int unsigned in_idle_pct  = 0;
    int unsigned out_idle_pct = 0;
    bit          hold_request = 1'b0;
    int unsigned hold_left    = 0;

    integer_to_ascii_formatter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Text the block should produce for one request, queued most significant first
    function automatic void format_number(input logic [2:0] m, input logic [63:0] v);
        logic [31:0] low;
        logic [63:0] mag;
        logic [63:0] base;
        string       digit_set;
        text_char_t  text[$];
        text_char_t  one;
        int          d;
        low       = v[31:0];
        base      = 64'd10;
        digit_set = "0123456789abcdef";
        one.last  = 1'b0;
        case (m)
            i2a_pkg::MODE_SDEC:
            begin
                if (low[31])
                begin
                    one.ch = i2a_pkg::CH_MINUS;
                    text.push_back(one);
                    low = -low;
                end
                mag = {32'd0, low};
            end
            i2a_pkg::MODE_UDEC:
                mag = {32'd0, low};
            i2a_pkg::MODE_PTR:
            begin
                one.ch = i2a_pkg::CH_ZERO;
                text.push_back(one);
                one.ch = i2a_pkg::CH_X;
                text.push_back(one);
                mag  = v;
                base = 64'd16;
            end
            i2a_pkg::MODE_LHEX:
            begin
                mag  = {32'd0, low};
                base = 64'd16;
            end
            i2a_pkg::MODE_UHEX:
            begin
                mag       = {32'd0, low};
                base      = 64'd16;
                digit_set = "0123456789ABCDEF";
            end
            default:
                return;
        endcase
        // digits come out least significant first; insert behind any prefix
        begin
            text_char_t digits[$];
            do
            begin
                d = int'(mag % base);
                one.ch = 7'(digit_set[d]);
                digits.push_front(one);
                mag = mag / base;
            end
            while (mag != 0);
            foreach (digits[i])
                text.push_back(digits[i]);
        end
        text[text.size() - 1].last = 1'b1;
        foreach (text[i])
            expected_chars.push_back(text[i]);
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: v = v >> $urandom_range(0, 63);
            1: v[31:0] = v[31:0] >> $urandom_range(0, 31);
            default: ;
        endcase
        return v;
    endfunction

    // Offer one request, hold it until accepted, then note the expected text
    task automatic send_request(input logic [2:0] m, input logic [63:0] v);
        while (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        format_number(m, v);
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_chars.size() != 0)
            @(posedge clk);
    endtask

    // Sign handling, most negative int, high word ignored
    task automatic test_signed_decimal();
        send_request(i2a_pkg::MODE_SDEC, 64'd0);
        send_request(i2a_pkg::MODE_SDEC, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(i2a_pkg::MODE_SDEC, 64'h1234_5678_7FFF_FFFF);
        send_request(i2a_pkg::MODE_SDEC, 64'h0000_0000_8000_0000);
        send_request(i2a_pkg::MODE_SDEC, 64'hDEAD_BEEF_FFFF_FFF6);
        send_request(i2a_pkg::MODE_SDEC, 64'd9);
        end_burst();
    endtask

    task automatic test_unsigned_decimal();
        send_request(i2a_pkg::MODE_UDEC, 64'hFFFF_FFFF_0000_0000);
        send_request(i2a_pkg::MODE_UDEC, 64'h0000_0000_FFFF_FFFF);
        send_request(i2a_pkg::MODE_UDEC, 64'd1000000000);
        send_request(i2a_pkg::MODE_UDEC, 64'h0000_0000_8000_0000);
        end_burst();
    endtask

    // Zero gives 0x0, all ones gives the longest text
    task automatic test_pointer_hex();
        send_request(i2a_pkg::MODE_PTR, 64'd0);
        send_request(i2a_pkg::MODE_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(i2a_pkg::MODE_PTR, 64'h8000_0000_0000_0000);
        send_request(i2a_pkg::MODE_PTR, 64'h0000_0000_DEAD_BEEF);
        end_burst();
    endtask

    task automatic test_plain_hex();
        send_request(i2a_pkg::MODE_LHEX, 64'hFFFF_FFFF_0000_0000);
        send_request(i2a_pkg::MODE_LHEX, 64'h0000_0000_FFFF_FFFF);
        send_request(i2a_pkg::MODE_LHEX, 64'h5555_5555_ABCD_EF01);
        send_request(i2a_pkg::MODE_UHEX, 64'hAAAA_AAAA_0000_0000);
        send_request(i2a_pkg::MODE_UHEX, 64'h0000_0000_FFFF_FFFF);
        send_request(i2a_pkg::MODE_UHEX, 64'h0000_0000_0A1B_2C3F);
        end_burst();
    endtask

    // Undefined modes must produce no characters
    task automatic test_reserved_modes();
        logic [2:0] m;
        for (m = MODE_RSVD_LO; m != i2a_pkg::MODE_SDEC; m++)
        begin
            send_request(m, random_value());
            send_request(i2a_pkg::MODE_UDEC, 64'd7);
        end
        end_burst();
    endtask

    task automatic test_random_stream(input int count, input int unsigned idle_pct);
        int sent;
        sent         = 0;
        in_idle_pct  = idle_pct;
        out_idle_pct = idle_pct;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 5)
                send_request(3'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI)), random_value());
            else
            begin
                send_request(3'($urandom_range(i2a_pkg::MODE_SDEC, i2a_pkg::MODE_UHEX)),
                             random_value());
                sent++;
            end
        end
        end_burst();
    endtask

    // Receiver holds off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        hold_request = 1'b1;
        repeat (12)
            send_request(i2a_pkg::MODE_PTR, {$urandom, $urandom} | 64'hF000_0000_0000_0000);
        end_burst();
        wait_drained();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_signed_decimal();
        test_unsigned_decimal();
        test_pointer_hex();
        test_plain_hex();
        test_reserved_modes();
        test_random_stream(RANDOM_QUIET, 0);
        test_backpressure();
        test_random_stream(RANDOM_BUSY, 10);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** integer_to_ascii_formatter: PASSED **");
        else
            $display("** integer_to_ascii_formatter: FAILED **");
        $finish;
    end

    // Receiver stall: random idling, or a long hold when one is requested
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= (out_idle_pct != 0) && ($urandom_range(0, 99) < out_idle_pct);
    end

    // Compare each accepted character with the oldest expectation
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("character: expected none, got %0h", character);
                mismatches++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (character !== want.ch)
                begin
                    $error("character: expected %0h, got %0h", want.ch, character);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** integer_to_ascii_formatter: FAILED **");
            $finish;
        end
    end

endmodule
